FILE: src/bezier_curve_tessellator_macros.svh
// assertion macros for the bezier curve tessellator checker
// needs a clock named clk and a reset named rst in the including scope
`ifndef BEZIER_CURVE_TESSELLATOR_MACROS_SVH
`define BEZIER_CURVE_TESSELLATOR_MACROS_SVH

// same-cycle implication, off during reset
`define BCT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bct port check failed");

// next-cycle implication, off during reset
`define BCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bct port check failed");

// next-cycle implication that also holds across reset
`define BCT_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bct reset check failed");

`endif

FILE: src/bct_pkg.sv
// shared types and constants of the bezier curve tessellator
// no dependencies
`timescale 1ns / 1ps

package bct_pkg;

  localparam int TESS_BITS = 6;
  localparam logic [TESS_BITS-1:0] TESS_RESET = 6'd10;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_PRE,
    ST_DIV,
    ST_FIX,
    ST_STORE,
    ST_EMIT,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic                 accept;
    logic [1:0]           slot;
    logic                 load_p;
    logic                 mul;
    logic                 pre;
    logic                 div_step;
    logic                 fix;
    logic                 level_last;
    logic [1:0]           lev;
    logic                 store;
    logic [1:0]           coord;
    logic                 emit;
    logic                 last;
    logic [TESS_BITS-1:0] l;
    logic                 shift_window;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [TESS_BITS-1:0] tess_eff;
    logic                 out_free;
  } status_t;

endpackage

FILE: src/bct_if.sv
// word channels of the bezier curve tessellator: control points in, curve points out
// no dependencies
`timescale 1ns / 1ps

interface bct_pt_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               curve_end;

  modport source (output valid, point_x, point_y, point_z, curve_end, input ready);
  modport sink (input valid, point_x, point_y, point_z, curve_end, output ready);
endinterface

interface bct_curve_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] curve_x;
  logic signed [31:0] curve_y;
  logic signed [31:0] curve_z;
  logic               run_last;

  modport source (output valid, curve_x, curve_y, curve_z, run_last, input ready);
  modport sink (input valid, curve_x, curve_y, curve_z, run_last, output ready);
endinterface

FILE: src/bezier_curve_tessellator.sv
// a point that does not complete a segment is only written into the window; a completing point
// yields T+1 curve points, T the tessellation; per point and coordinate the lerp unit loads the row,
// runs multiply, prepare, bit-serial divide and fix for each lerp of every level, then stores
// throughput: one control point at a time; a finished word waits in the output register
// reset: tessellation 10, window empty, output empty; no clearing pass
// top level: joins controller, datapath and the two word channels; depends on bct_pkg, bct_if, bct_ctrl, bct_dp
`timescale 1ns / 1ps

module bezier_curve_tessellator #(
  parameter int MAX_TESSELLATION = 63,
  parameter int COORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tessellation_we,
  input  logic [bct_pkg::TESS_BITS-1:0] tessellation_wdata,
  bct_pt_if.sink                        ctrl_pt,
  bct_curve_if.source                   curve_pt
);

  bct_pkg::cmd_t    cmd;
  bct_pkg::status_t status;

  // sequencing
  bct_ctrl #(
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ctrl_pt.valid),
    .curve_end(ctrl_pt.curve_end),
    .in_ready (ctrl_pt.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and storage
  bct_dp #(
    .COORD_BITS      (COORD_BITS),
    .MAX_TESSELLATION(MAX_TESSELLATION)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .tessellation_we   (tessellation_we),
    .tessellation_wdata(tessellation_wdata),
    .point_x           (ctrl_pt.point_x),
    .point_y           (ctrl_pt.point_y),
    .point_z           (ctrl_pt.point_z),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (curve_pt.valid),
    .out_ready         (curve_pt.ready),
    .curve_x           (curve_pt.curve_x),
    .curve_y           (curve_pt.curve_y),
    .curve_z           (curve_pt.curve_z),
    .run_last          (curve_pt.run_last)
  );

endmodule

FILE: src/bct_dp.sv
// datapath: control point window, serial lerp unit with bit-serial divider, output register
// depends on bct_pkg
`timescale 1ns / 1ps

module bct_dp #(
  parameter int COORD_BITS = 32,
  parameter int MAX_TESSELLATION = 63
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tessellation_we,
  input  logic [bct_pkg::TESS_BITS-1:0]  tessellation_wdata,
  input  logic signed [31:0]             point_x,
  input  logic signed [31:0]             point_y,
  input  logic signed [31:0]             point_z,
  input  bct_pkg::cmd_t                  cmd,
  output bct_pkg::status_t               status,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             curve_x,
  output logic signed [31:0]             curve_y,
  output logic signed [31:0]             curve_z,
  output logic                           run_last
);

  localparam int CW = COORD_BITS;
  localparam int DW = COORD_BITS + 8;
  localparam int TB = bct_pkg::TESS_BITS;

  function automatic logic signed [CW-1:0] sat_in(input logic signed [31:0] x);
    logic signed [63:0] v;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    v  = 64'(x);
    hi = (64'sd1 <<< (CW - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return CW'(v);
  endfunction

  function automatic logic signed [31:0] sat_out(input logic signed [CW-1:0] x);
    logic signed [63:0] v;
    v = 64'(x);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return 32'(v);
  endfunction

  logic [TB-1:0]          tess;
  logic [TB-1:0]          tess_eff;
  logic signed [CW-1:0]   win [4][3];
  logic signed [CW-1:0]   p [4];
  logic signed [CW-1:0]   res [3];
  logic signed [DW-1:0]   prod;
  logic [DW-1:0]          mag;
  logic [DW-1:0]          quo;
  logic [TB-1:0]          rem;
  logic                   neg;
  logic signed [CW:0]     diff;
  logic signed [TB:0]     l_s;
  logic signed [DW-1:0]   dsum;
  logic [TB:0]            trial;
  logic                   qbit;
  logic signed [DW:0]     qs;
  logic signed [DW:0]     fq;
  logic signed [DW:0]     qsum;
  logic signed [CW-1:0]   q;

  // tessellation register and its clamped value
  always_ff @(posedge clk) begin
    if (rst) begin
      tess <= bct_pkg::TESS_RESET;
    end else if (tessellation_we) begin
      tess <= tessellation_wdata;
    end
  end

  always_comb begin
    if (tess == '0) begin
      tess_eff = TB'(1);
    end else if (tess > TB'(MAX_TESSELLATION)) begin
      tess_eff = TB'(MAX_TESSELLATION);
    end else begin
      tess_eff = tess;
    end
  end

  // control point window
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      win[cmd.slot][0] <= sat_in(point_x);
      win[cmd.slot][1] <= sat_in(point_y);
      win[cmd.slot][2] <= sat_in(point_z);
    end else if (cmd.shift_window) begin
      win[0][0] <= win[3][0];
      win[0][1] <= win[3][1];
      win[0][2] <= win[3][2];
    end
  end

  // lerp arithmetic around the serial divider
  always_comb begin
    diff  = $signed({p[1][CW-1], p[1]}) - $signed({p[0][CW-1], p[0]});
    l_s   = $signed({1'b0, cmd.l});
    dsum  = prod + $signed(DW'(tess_eff >> 1));
    trial = {rem, mag[DW-1]};
    qbit  = (trial >= {1'b0, tess_eff});
    qs    = $signed({1'b0, quo});
    // floor for a negative numerator: minus quotient, one lower on a remainder
    if (neg) begin
      fq = (rem != '0) ? ~qs : -qs;
    end else begin
      fq = qs;
    end
    qsum = fq + (DW+1)'(p[0]);
    q    = qsum[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= diff * l_s;
    end
    if (cmd.pre) begin
      neg <= dsum[DW-1];
      mag <= dsum[DW-1] ? DW'(-dsum) : DW'(dsum);
      rem <= '0;
    end else if (cmd.div_step) begin
      mag <= {mag[DW-2:0], 1'b0};
      quo <= {quo[DW-2:0], qbit};
      rem <= qbit ? TB'(trial - {1'b0, tess_eff}) : trial[TB-1:0];
    end
  end

  // de casteljau working row: reads at the low end, result lands at the level top
  always_ff @(posedge clk) begin
    if (cmd.load_p) begin
      for (int k = 0; k < 4; k++) begin
        p[k] <= win[k][cmd.coord];
      end
    end else if (cmd.fix) begin
      if (cmd.level_last) begin
        p[0] <= p[2];
        p[1] <= p[3];
        p[cmd.lev - 2'd1] <= q;
      end else begin
        p[0] <= p[1];
        p[1] <= p[2];
        p[2] <= p[3];
        p[cmd.lev] <= q;
      end
    end
  end

  // finished coordinates of the current curve point
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      res[cmd.coord] <= p[0];
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      curve_x  <= sat_out(res[0]);
      curve_y  <= sat_out(res[1]);
      curve_z  <= sat_out(res[2]);
      run_last <= cmd.last;
    end
  end

  // status back to the controller
  always_comb begin
    status.tess_eff = tess_eff;
    status.out_free = !out_valid || out_ready;
  end

endmodule

FILE: src/bct_ctrl.sv
// controller: sequences window writes, lerp levels, coordinates and curve points
// depends on bct_pkg
`timescale 1ns / 1ps

module bct_ctrl #(
  parameter int COORD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             curve_end,
  output logic             in_ready,
  input  bct_pkg::status_t status,
  output bct_pkg::cmd_t    cmd
);

  localparam int DW = COORD_BITS + 8;
  localparam int CB = $clog2(DW);
  localparam int TB = bct_pkg::TESS_BITS;

  bct_pkg::state_t state;
  bct_pkg::state_t state_next;
  logic [1:0]      held;
  logic            end_flag;
  logic [TB-1:0]   l;
  logic [1:0]      coord;
  logic [1:0]      lev;
  logic [1:0]      j;
  logic [CB-1:0]   cnt;
  logic            level_last;
  logic            at_last;

  assign level_last = (j == lev - 2'd1);
  assign at_last    = (l == status.tess_eff);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bct_pkg::ST_IDLE: begin
        if (in_valid && held == 2'd3) state_next = bct_pkg::ST_LOAD;
      end
      bct_pkg::ST_LOAD: state_next = bct_pkg::ST_MUL;
      bct_pkg::ST_MUL:  state_next = bct_pkg::ST_PRE;
      bct_pkg::ST_PRE:  state_next = bct_pkg::ST_DIV;
      bct_pkg::ST_DIV: begin
        if (cnt == CB'(DW - 1)) state_next = bct_pkg::ST_FIX;
      end
      bct_pkg::ST_FIX: begin
        state_next = (level_last && lev == 2'd1) ? bct_pkg::ST_STORE : bct_pkg::ST_MUL;
      end
      bct_pkg::ST_STORE: begin
        state_next = (coord == 2'd2) ? bct_pkg::ST_EMIT : bct_pkg::ST_LOAD;
      end
      bct_pkg::ST_EMIT: begin
        if (status.out_free) state_next = at_last ? bct_pkg::ST_DONE : bct_pkg::ST_LOAD;
      end
      bct_pkg::ST_DONE: state_next = bct_pkg::ST_IDLE;
      default:          state_next = bct_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd            = '0;
    cmd.slot       = held;
    cmd.coord      = coord;
    cmd.lev        = lev;
    cmd.level_last = level_last;
    cmd.l          = l;
    cmd.last       = at_last;
    in_ready       = 1'b0;
    unique case (state)
      bct_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      bct_pkg::ST_LOAD:  cmd.load_p = 1'b1;
      bct_pkg::ST_MUL:   cmd.mul = 1'b1;
      bct_pkg::ST_PRE:   cmd.pre = 1'b1;
      bct_pkg::ST_DIV:   cmd.div_step = 1'b1;
      bct_pkg::ST_FIX:   cmd.fix = 1'b1;
      bct_pkg::ST_STORE: cmd.store = 1'b1;
      bct_pkg::ST_EMIT:  cmd.emit = status.out_free;
      bct_pkg::ST_DONE:  cmd.shift_window = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // loop counters and window fill
  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= '0;
      end_flag <= 1'b0;
      l        <= '0;
      coord    <= '0;
      lev      <= '0;
      j        <= '0;
      cnt      <= '0;
    end else begin
      case (state)
        bct_pkg::ST_IDLE: begin
          if (in_valid) begin
            end_flag <= curve_end;
            l        <= '0;
            coord    <= '0;
            if (held != 2'd3) held <= curve_end ? 2'd0 : held + 2'd1;
          end
        end
        bct_pkg::ST_LOAD: begin
          lev <= 2'd3;
          j   <= '0;
        end
        bct_pkg::ST_PRE: cnt <= '0;
        bct_pkg::ST_DIV: cnt <= cnt + CB'(1);
        bct_pkg::ST_FIX: begin
          if (level_last) begin
            lev <= lev - 2'd1;
            j   <= '0;
          end else begin
            j <= j + 2'd1;
          end
        end
        bct_pkg::ST_STORE: coord <= coord + 2'd1;
        bct_pkg::ST_EMIT: begin
          if (status.out_free && !at_last) begin
            l     <= l + TB'(1);
            coord <= '0;
          end
        end
        bct_pkg::ST_DONE: held <= end_flag ? 2'd0 : 2'd1;
        default: ;
      endcase
    end
  end

endmodule

FILE: src/bct_checker.sv
// port checker for the bezier curve tessellator, bound to the top level
// depends on bezier_curve_tessellator_macros.svh
`timescale 1ns / 1ps
`include "bezier_curve_tessellator_macros.svh"

module bct_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [96:0] out_word
);

  // a held output word stays put until taken
  `BCT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
  // an idle input with nothing offered stays ready
  `BCT_ASSERT_NEXT(a_in_idle, in_ready && !in_valid, in_ready)
  // nothing is shown right after reset
  `BCT_ASSERT_RST(a_reset_empty, rst, !out_valid)

endmodule

bind bezier_curve_tessellator bct_port_checker u_bct_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (ctrl_pt.valid),
  .in_ready (ctrl_pt.ready),
  .out_valid(curve_pt.valid),
  .out_ready(curve_pt.ready),
  .out_word ({curve_pt.curve_x, curve_pt.curve_y, curve_pt.curve_z, curve_pt.run_last})
);

FILE: test/bct_checker.sv
// curve point checker of the bezier curve tessellator: predicts curve words and compares them
// depends on bct_pkg and the word channel interfaces in bct_if
`timescale 1ns / 1ps

module bct_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tessellation_we,
  input  logic [bct_pkg::TESS_BITS-1:0] tessellation_wdata,
  bct_pt_if                             ctrl_pt,
  bct_curve_if                          curve_pt,
  output int                            mismatches,
  output int                            pending
);

  localparam int MAX_TESS = 63;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } curve_word_t;

  curve_word_t                   curve_q[$];
  logic signed [31:0]            window[4][3];
  logic [1:0]                    held;
  logic [bct_pkg::TESS_BITS-1:0] tess;

  // one interpolation level, rounded to nearest with ties upward
  function automatic longint lerp_round(longint a, longint b, longint l, longint t);
    longint num;
    longint q;
    num = (t - l) * a + l * b + t / 2;
    q = num / t;
    if ((num % t) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // de casteljau over the full window, one word per parameter step
  task automatic tessellate_segment();
    longint t;
    longint p[4];
    logic signed [31:0] crd[3];
    curve_word_t w;
    t = tess;
    if (t < 1) t = 1;
    if (t > MAX_TESS) t = MAX_TESS;
    for (longint l = 0; l <= t; l++) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 4; k++) p[k] = window[k][c];
        for (int lev = 3; lev > 0; lev--)
          for (int j = 0; j < lev; j++) p[j] = lerp_round(p[j], p[j+1], l, t);
        crd[c] = clip32(p[0]);
      end
      w.x = crd[0];
      w.y = crd[1];
      w.z = crd[2];
      w.last = (l == t);
      curve_q = {curve_q, w};
    end
  endtask

  always @(posedge clk) begin
    curve_word_t got;
    curve_word_t want;
    logic [1:0] slot;
    if (rst) begin
      tess = bct_pkg::TESS_RESET;
      held = '0;
      mismatches = 0;
      curve_q.delete();
      for (int k = 0; k < 4; k++)
        for (int c = 0; c < 3; c++) window[k][c] = '0;
    end else begin
      if (tessellation_we) tess = tessellation_wdata;
      // outgoing curve word
      if (curve_pt.valid && curve_pt.ready) begin
        got = {curve_pt.curve_x, curve_pt.curve_y, curve_pt.curve_z, curve_pt.run_last};
        if (curve_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected curve word x=%h y=%h z=%h last=%b",
                     got.x, got.y, got.z, got.last);
        end else begin
          want = curve_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"curve word wrong: exp x=%h y=%h z=%h last=%b, ",
                        "got x=%h y=%h z=%h last=%b"},
                       want.x, want.y, want.z, want.last, got.x, got.y, got.z, got.last);
          end
        end
      end
      // incoming control point
      if (ctrl_pt.valid && ctrl_pt.ready) begin
        slot = held;
        window[slot][0] = ctrl_pt.point_x;
        window[slot][1] = ctrl_pt.point_y;
        window[slot][2] = ctrl_pt.point_z;
        if (slot == 2'd3) begin
          tessellate_segment();
          for (int c = 0; c < 3; c++) window[0][c] = window[3][c];
          held = 2'd1;
        end else begin
          held = slot + 2'd1;
        end
        if (ctrl_pt.curve_end) held = '0;
      end
    end
    pending = curve_q.size();
  end

endmodule

FILE: test/tb.sv
// stimulus and verdict for the bezier curve tessellator
// depends on bct_pkg, bct_if, the block and bct_checker
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  logic                          clk;
  logic                          rst;
  logic                          tessellation_we;
  logic [bct_pkg::TESS_BITS-1:0] tessellation_wdata;
  int                            mismatches;
  int                            pending;
  int                            send_idle;
  int                            recv_idle;
  bit                            hold_req;
  int                            quiet_cycles;

  bct_pt_if    pt_ch ();
  bct_curve_if cv_ch ();

  bezier_curve_tessellator DUT (
    .clk                (clk),
    .rst                (rst),
    .tessellation_we    (tessellation_we),
    .tessellation_wdata (tessellation_wdata),
    .ctrl_pt            (pt_ch),
    .curve_pt           (cv_ch)
  );

  bct_checker checker_i (
    .clk                (clk),
    .rst                (rst),
    .tessellation_we    (tessellation_we),
    .tessellation_wdata (tessellation_wdata),
    .ctrl_pt            (pt_ch),
    .curve_pt           (cv_ch),
    .mismatches         (mismatches),
    .pending            (pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // receiver side, with the long hold-off on request
  initial begin
    cv_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        cv_ch.ready <= 0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        cv_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // watchdog on cycles without any accepted word
  initial begin
    quiet_cycles = 0;
    forever begin
      @(negedge clk);
      if ((pt_ch.valid && pt_ch.ready) || (cv_ch.valid && cv_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(2097151) - 32'd1048576;
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return ($urandom_range(511) - 32'd256) << 16;
    endcase
  endfunction

  // offer one control point, called just after a rising edge
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic e);
    logic r;
    while ($urandom_range(99) < send_idle) begin
      pt_ch.valid <= 0;
      @(posedge clk);
    end
    pt_ch.valid <= 1;
    pt_ch.point_x <= x;
    pt_ch.point_y <= y;
    pt_ch.point_z <= z;
    pt_ch.curve_end <= e;
    do begin
      @(negedge clk);
      r = pt_ch.ready;
      @(posedge clk);
    end while (!r);
  endtask

  // stop offering and wait until every curve word is out
  task automatic drain();
    pt_ch.valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_tess(logic [bct_pkg::TESS_BITS-1:0] v);
    tessellation_we <= 1;
    tessellation_wdata <= v;
    @(posedge clk);
    tessellation_we <= 0;
    @(posedge clk);
  endtask

  task automatic send_curve(int len);
    for (int i = 0; i < len; i++)
      send_point(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
  endtask

  initial begin
    int tess_list[6];
    int sent;
    int len;
    tess_list = '{1, 2, 3, 4, 6, 2};
    rst = 1;
    tessellation_we = 0;
    tessellation_wdata = '0;
    pt_ch.valid = 0;
    pt_ch.point_x = '0;
    pt_ch.point_y = '0;
    pt_ch.point_z = '0;
    pt_ch.curve_end = 0;
    send_idle = 8;
    recv_idle = 60;
    hold_req = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset tessellation: extremes, two segments with a shared joint
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
    send_point(32'h80000000, 32'h7fffffff, 32'h80000000, 0);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h80000000, 0);
    send_point(32'h80000000, 32'h80000000, 32'h7fffffff, 0);
    send_point(32'h00000000, 32'h00000000, 32'h00000000, 0);
    send_point(32'h00000001, 32'hffffffff, 32'h00010000, 0);
    send_point(32'hffffffff, 32'h00000001, 32'hffff0000, 1);
    // end mark on an incomplete segment
    send_point(32'h00010000, 32'h00020000, 32'h00030000, 0);
    send_point(32'h00040000, 32'h00050000, 32'h00060000, 1);
    send_point(32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f, 1);
    send_curve(4);
    drain();

    // tessellation zero acts as one
    write_tess(6'd0);
    send_curve(4);
    drain();

    // largest tessellation
    write_tess(6'd63);
    send_curve(4);
    drain();

    // random curves over several settings and idling patterns
    for (int p = 0; p < 6; p++) begin
      write_tess(6'(tess_list[p]));
      send_idle = (p < 2) ? 8 : ((p < 4) ? 60 : 0);
      recv_idle = (p < 2) ? 60 : ((p < 4) ? 8 : 0);
      if (p == 1) hold_req = 1;
      sent = 0;
      while (sent < 22) begin
        if ($urandom_range(7) == 0) len = $urandom_range(1, 9);
        else len = 1 + 3 * $urandom_range(1, 3);
        send_curve(len);
        sent += len;
      end
      drain();
    end

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/bct_pkg.sv
src/bct_if.sv
src/bct_dp.sv
src/bct_ctrl.sv
src/bezier_curve_tessellator.sv
src/bct_checker.sv
test/bct_checker.sv
test/tb.sv
